/* rtl/tlpt_pkg.sv */
// Package for the two-level page table walker: sizes, codes and types.
`timescale 1ns / 1ps

package tlpt_pkg;

  localparam int NUM_PROCS     = 16;
  localparam int PAGE_COUNT    = 256;
  localparam int FRAME_COUNT   = 256;
  localparam int UPPER_ENTRIES = 16;

  localparam int PROC_W  = $clog2(NUM_PROCS);
  localparam int PAGE_W  = $clog2(PAGE_COUNT);
  localparam int UIDX_W  = $clog2(UPPER_ENTRIES);
  localparam int FRAME_W = $clog2(FRAME_COUNT);
  localparam int FNUM_W  = $clog2(FRAME_COUNT + 1);
  localparam int REF_W   = 8;
  localparam int FAULT_W = 16;

  localparam int UPPER_DEPTH = NUM_PROCS * UPPER_ENTRIES;
  localparam int LOWER_DEPTH = NUM_PROCS * PAGE_COUNT;
  localparam int UADDR_W     = $clog2(UPPER_DEPTH);
  localparam int LADDR_W     = $clog2(LOWER_DEPTH);

  localparam int RESV_W   = 5;
  localparam int IBITS_W  = 4;
  localparam int MIN_BITS = 4;
  localparam int MAX_BITS = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOTAL_FRAMES    = 2'd0,
    CFG_RESERVED_FRAMES = 2'd1,
    CFG_INDEX_BITS      = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  typedef struct packed {
    logic               valid;
    logic [FRAME_W-1:0] frame;
    logic [REF_W-1:0]   refc;
  } lower_entry_t;

endpackage

/* rtl/two_level_page_table_demand_alloc_top.sv */
// Two-level page table walker with demand frame allocation and per-process fault counts.
`timescale 1ns / 1ps

// Each request (process, virtual page) is handled in steps: the accept reads the upper frame
// memory and the lower entry memory (synchronous reads), then the lookup step updates
// the entries, the bump allocator and the fault count and loads the result register.
// A new request is accepted in the cycle after the write-back; the write-back waits
// while the previous result is still held in the output register. After reset the
// lower entry memory is swept clear, every entry, before the first request is
// accepted; configuration writes are taken during the sweep. Once frames run out the
// block reports out_of_memory for that and every later request.
module two_level_page_table_demand_alloc_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [tlpt_pkg::PROC_W-1:0]         in_process_id,
  input  logic [tlpt_pkg::PAGE_W-1:0]         in_page,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [tlpt_pkg::FRAME_W-1:0]        out_upper_frame,
  output logic                                out_upper_fault,
  output logic [tlpt_pkg::FRAME_W-1:0]        out_lower_frame,
  output logic                                out_lower_fault,
  output logic [tlpt_pkg::REF_W-1:0]          out_lower_ref_count,
  output logic [tlpt_pkg::FAULT_W-1:0]        out_process_faults,
  output logic                                out_out_of_memory,
  input  logic                                cfg_we,
  input  logic [tlpt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tlpt_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  tlpt_pkg::state_t state_r, state_nxt;

  logic [tlpt_pkg::LADDR_W-1:0]   clr_addr_r;
  logic [tlpt_pkg::FNUM_W-1:0]    total_frames_r;
  logic [tlpt_pkg::RESV_W-1:0]    reserved_frames_r;
  logic [tlpt_pkg::IBITS_W-1:0]   index_bits_r;
  logic [tlpt_pkg::UPPER_DEPTH-1:0] upper_valid_r;
  logic [tlpt_pkg::FAULT_W-1:0]   fault_counts_r [tlpt_pkg::NUM_PROCS];
  logic [tlpt_pkg::FNUM_W-1:0]    next_frame_r;
  logic                           halted_r;

  logic [tlpt_pkg::PROC_W-1:0]    req_pid_r;
  logic [tlpt_pkg::UADDR_W-1:0]   uaddr_r;
  logic [tlpt_pkg::LADDR_W-1:0]   laddr_r;
  logic [tlpt_pkg::FRAME_W-1:0]   upper_rd_r;
  tlpt_pkg::lower_entry_t         lower_rd_r;

  logic [tlpt_pkg::FRAME_W-1:0]   upper_mem [tlpt_pkg::UPPER_DEPTH];
  tlpt_pkg::lower_entry_t         lower_mem [tlpt_pkg::LOWER_DEPTH];

  logic                           out_valid_r;
  logic [tlpt_pkg::FRAME_W-1:0]   out_upper_frame_r;
  logic                           out_upper_fault_r;
  logic [tlpt_pkg::FRAME_W-1:0]   out_lower_frame_r;
  logic                           out_lower_fault_r;
  logic [tlpt_pkg::REF_W-1:0]     out_lower_ref_r;
  logic [tlpt_pkg::FAULT_W-1:0]   out_faults_r;
  logic                           out_oom_r;

  logic                           accept;
  logic                           done;
  logic                           clr_last;
  logic [tlpt_pkg::IBITS_W-1:0]   sat_bits;
  logic [tlpt_pkg::UIDX_W-1:0]    in_uidx;
  logic [tlpt_pkg::UADDR_W-1:0]   in_uaddr;
  logic [tlpt_pkg::LADDR_W-1:0]   in_laddr;

  logic [tlpt_pkg::FNUM_W-1:0]    limit;
  logic [tlpt_pkg::FNUM_W-1:0]    resv_ext;
  logic [tlpt_pkg::FNUM_W-1:0]    cand0;
  logic [tlpt_pkg::FNUM_W-1:0]    cand_l;
  logic [tlpt_pkg::FNUM_W-1:0]    next_after;
  logic                           uv;
  logic                           lv;
  logic                           u_ok;
  logic                           l_ok;
  logic [tlpt_pkg::FRAME_W-1:0]   ufr;
  logic [tlpt_pkg::FAULT_W-1:0]   fc0;
  logic [tlpt_pkg::FAULT_W-1:0]   fc1;
  logic [tlpt_pkg::FAULT_W-1:0]   fc2;
  tlpt_pkg::lower_entry_t         lower_new;
  logic                           live;
  logic                           upd_u;
  logic                           upd_l;
  logic                           lmem_we;
  logic [tlpt_pkg::LADDR_W-1:0]   lmem_waddr;
  tlpt_pkg::lower_entry_t         lmem_wdata;

  // ---------------------------------------------------------------- control
  assign clr_last = (clr_addr_r == tlpt_pkg::LADDR_W'(tlpt_pkg::LOWER_DEPTH - 1));
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tlpt_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    done      = 1'b0;
    unique case (state_r)
      tlpt_pkg::ST_CLEAR: begin
        if (clr_last) state_nxt = tlpt_pkg::ST_IDLE;
      end
      tlpt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_nxt = tlpt_pkg::ST_LOOKUP;
      end
      tlpt_pkg::ST_LOOKUP: begin
        // hold the write-back while the previous result is still waiting
        done = !out_valid_r || out_ready;
        if (done) state_nxt = tlpt_pkg::ST_IDLE;
      end
      default: state_nxt = tlpt_pkg::ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (state_r == tlpt_pkg::ST_CLEAR) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  // ---------------------------------------------------------- configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_frames_r    <= tlpt_pkg::FNUM_W'(tlpt_pkg::FRAME_COUNT);
      reserved_frames_r <= '0;
      index_bits_r      <= tlpt_pkg::IBITS_W'(tlpt_pkg::MIN_BITS);
    end else if (cfg_we) begin
      case (cfg_index)
        tlpt_pkg::CFG_TOTAL_FRAMES:    total_frames_r    <= cfg_wdata[tlpt_pkg::FNUM_W-1:0];
        tlpt_pkg::CFG_RESERVED_FRAMES: reserved_frames_r <= cfg_wdata[tlpt_pkg::RESV_W-1:0];
        tlpt_pkg::CFG_INDEX_BITS:      index_bits_r      <= cfg_wdata[tlpt_pkg::IBITS_W-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------- address decode
  always_comb begin
    if (index_bits_r < tlpt_pkg::IBITS_W'(tlpt_pkg::MIN_BITS)) begin
      sat_bits = tlpt_pkg::IBITS_W'(tlpt_pkg::MIN_BITS);
    end else if (index_bits_r > tlpt_pkg::IBITS_W'(tlpt_pkg::MAX_BITS)) begin
      sat_bits = tlpt_pkg::IBITS_W'(tlpt_pkg::MAX_BITS);
    end else begin
      sat_bits = index_bits_r;
    end
  end

  assign in_uidx  = tlpt_pkg::UIDX_W'(in_page >> sat_bits);
  assign in_uaddr = {in_process_id, in_uidx};
  assign in_laddr = {in_process_id, in_page};

  always_ff @(posedge clk) begin
    if (accept) begin
      req_pid_r <= in_process_id;
      uaddr_r   <= in_uaddr;
      laddr_r   <= in_laddr;
    end
  end

  // ---------------------------------------------------------------- memories
  always_ff @(posedge clk) begin
    if (upd_u) upper_mem[uaddr_r] <= cand0[tlpt_pkg::FRAME_W-1:0];
    if (accept) upper_rd_r <= upper_mem[in_uaddr];
  end

  assign lmem_we    = (state_r == tlpt_pkg::ST_CLEAR) || upd_l;
  assign lmem_waddr = (state_r == tlpt_pkg::ST_CLEAR) ? clr_addr_r : laddr_r;
  assign lmem_wdata = (state_r == tlpt_pkg::ST_CLEAR) ? '0 : lower_new;

  always_ff @(posedge clk) begin
    if (lmem_we) lower_mem[lmem_waddr] <= lmem_wdata;
    if (accept) lower_rd_r <= lower_mem[in_laddr];
  end

  // ------------------------------------------------------- walk and allocate
  assign limit    = (total_frames_r > tlpt_pkg::FNUM_W'(tlpt_pkg::FRAME_COUNT))
                    ? tlpt_pkg::FNUM_W'(tlpt_pkg::FRAME_COUNT) : total_frames_r;
  assign resv_ext = tlpt_pkg::FNUM_W'(reserved_frames_r);
  assign cand0    = (next_frame_r < resv_ext) ? resv_ext : next_frame_r;

  assign uv     = upper_valid_r[uaddr_r];
  assign lv     = lower_rd_r.valid;
  assign u_ok   = uv || (cand0 < limit);
  // a fresh upper frame pushes the lower candidate one frame up
  assign cand_l = uv ? cand0 : cand0 + 1'b1;
  assign l_ok   = lv || (cand_l < limit);
  assign ufr    = uv ? upper_rd_r : cand0[tlpt_pkg::FRAME_W-1:0];

  assign fc0 = fault_counts_r[req_pid_r];
  assign fc1 = (!uv && (fc0 != '1)) ? fc0 + 1'b1 : fc0;
  assign fc2 = (!lv && (fc1 != '1)) ? fc1 + 1'b1 : fc1;

  always_comb begin
    lower_new.valid = 1'b1;
    if (lv) begin
      lower_new.frame = lower_rd_r.frame;
      lower_new.refc  = lower_rd_r.refc + 1'b1;
    end else begin
      lower_new.frame = cand_l[tlpt_pkg::FRAME_W-1:0];
      lower_new.refc  = tlpt_pkg::REF_W'(1);
    end
  end

  always_comb begin
    if (l_ok && !lv) begin
      next_after = cand_l + 1'b1;
    end else if (!uv) begin
      next_after = cand0 + 1'b1;
    end else begin
      next_after = next_frame_r;
    end
  end

  assign live  = done && !halted_r;
  assign upd_u = live && !uv && u_ok;
  assign upd_l = live && u_ok && l_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_valid_r <= '0;
      next_frame_r  <= '0;
      halted_r      <= 1'b0;
      for (int i = 0; i < tlpt_pkg::NUM_PROCS; i++) begin
        fault_counts_r[i] <= '0;
      end
    end else if (live) begin
      if (!u_ok || !l_ok) halted_r <= 1'b1;
      if (u_ok) begin
        next_frame_r               <= next_after;
        fault_counts_r[req_pid_r]  <= l_ok ? fc2 : fc1;
        upper_valid_r[uaddr_r]     <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------ result hold
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_upper_frame_r <= '0;
      out_upper_fault_r <= 1'b0;
      out_lower_frame_r <= '0;
      out_lower_fault_r <= 1'b0;
      out_lower_ref_r   <= '0;
      out_faults_r      <= '0;
      out_oom_r         <= 1'b1;
      if (!halted_r && u_ok) begin
        out_upper_frame_r <= ufr;
        out_upper_fault_r <= !uv;
        out_faults_r      <= fc1;
        if (l_ok) begin
          out_lower_frame_r <= lower_new.frame;
          out_lower_fault_r <= !lv;
          out_lower_ref_r   <= lower_new.refc;
          out_faults_r      <= fc2;
          out_oom_r         <= 1'b0;
        end
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_upper_frame     = out_upper_frame_r;
  assign out_upper_fault     = out_upper_fault_r;
  assign out_lower_frame     = out_lower_frame_r;
  assign out_lower_fault     = out_lower_fault_r;
  assign out_lower_ref_count = out_lower_ref_r;
  assign out_process_faults  = out_faults_r;
  assign out_out_of_memory   = out_oom_r;

endmodule
